/* sv/getmh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// getmh_pkg
// Shared widths, register indexes, state encoding and the command and status
// bundles that run between the edge-toggle controller and its datapath.
// ----------------------------------------------------------------------------
package getmh_pkg;

	// default graph capacity, rows of the adjacency memory
	localparam int MAX_NODES_DEF = 64;

	// fixed field widths
	localparam int NODE_W     = 6;
	localparam int NCOUNT_W   = 7;
	localparam int COEF_W     = 16;
	localparam int EDGE_W     = 11;
	localparam int TRI_W      = 16;
	localparam int TCHG_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = 7'd64;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NODE_COUNT = 2'd0,
		CFG_EDGE_COEF  = 2'd1,
		CFG_TRI_COEF   = 2'd2
	} cfg_idx_t;

	// action and status codes
	localparam logic ACT_FORCE     = 1'b0;
	localparam logic STAT_OK       = 1'b0;
	localparam logic STAT_BAD_PAIR = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDB,
		S_POP,
		S_SUM,
		S_EVAL,
		S_WRA,
		S_WRB,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;   // capture input beat, read row a
		logic rd_b;   // latch row a, read row b
		logic lat_b;  // latch row b, per-byte popcounts
		logic sum;    // add byte counts
		logic eval;   // log ratio and commit decision
		logic wr_a;   // write back row a
		logic wr_b;   // write back row b
		logic load;   // load output register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bad_pair;
	} dp_stat_t;

endpackage

/* sv/getmh_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// getmh_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module getmh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* sv/getmh_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// getmh_ctrl
// Sequencer for one dyad: two row reads, popcount, evaluate, two row
// writebacks, then load the output register; a bad pair skips to the load.
// ----------------------------------------------------------------------------
module getmh_ctrl import getmh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat_i,
	output dp_cmd_t  cmd_o
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = stat_i.bad_pair ? S_DONE : S_RDB;
				end
			end
			S_RDB:  state_d = S_POP;
			S_POP:  state_d = S_SUM;
			S_SUM:  state_d = S_EVAL;
			S_EVAL: state_d = S_WRA;
			S_WRA:  state_d = S_WRB;
			S_WRB:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd_o = '0;
		unique case (state_q)
			S_IDLE:  cmd_o.take  = accept;
			S_RDB:   cmd_o.rd_b  = 1'b1;
			S_POP:   cmd_o.lat_b = 1'b1;
			S_SUM:   cmd_o.sum   = 1'b1;
			S_EVAL:  cmd_o.eval  = 1'b1;
			S_WRA:   cmd_o.wr_a  = 1'b1;
			S_WRB:   cmd_o.wr_b  = 1'b1;
			S_DONE:  cmd_o.load  = out_free;
			default: cmd_o = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output beat pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_o.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_bad_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && stat_i.bad_pair) |=> (state_q == S_DONE))
		else $error("bad pair did not go straight to result");

	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("output beat raised outside result state");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && out_stall) |=> (state_q == S_DONE))
		else $error("result dropped while output slot busy");

endmodule

/* sv/getmh_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// getmh_dp
// Datapath: configuration registers, adjacency memory with per-row valid
// bits, common-neighbour popcount, log ratio evaluation and running counts.
// ----------------------------------------------------------------------------
module getmh_dp import getmh_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     action,
	input  logic [NODE_W-1:0]        node_a,
	input  logic [NODE_W-1:0]        node_b,
	input  logic signed [COEF_W-1:0] log_uniform,
	input  dp_cmd_t                  cmd_i,
	output dp_stat_t                 stat_o,
	output logic                     accepted,
	output logic                     status,
	output logic [EDGE_W-1:0]        edge_total,
	output logic [TRI_W-1:0]         triangle_total,
	output logic signed [TCHG_W-1:0] triangle_change
);

	localparam int IDX_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int LIM_W   = $clog2(MAX_NODES + 1);
	localparam int CMP_W   = (LIM_W > NCOUNT_W) ? LIM_W : NCOUNT_W;
	localparam int NGRP    = (MAX_NODES + 7) / 8;
	localparam int TD_W    = LIM_W + 1;
	localparam int PROD_W  = TD_W + COEF_W;
	localparam int RATIO_W = PROD_W + 1;
	localparam logic [MAX_NODES-1:0] ROW_ONE = MAX_NODES'(1);

	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

	// configuration
	logic [NCOUNT_W-1:0]      node_count_q;
	logic signed [COEF_W-1:0] ecoef_q;
	logic signed [COEF_W-1:0] tcoef_q;

	// item capture
	logic                     action_q;
	logic [IDX_W-1:0]         a_idx_q;
	logic [IDX_W-1:0]         b_idx_q;
	logic signed [COEF_W-1:0] draw_q;
	logic                     bad_q;

	// rows and counts
	logic [MAX_NODES-1:0] valid_q;
	logic                 rvalid_q;
	logic [MAX_NODES-1:0] rd_data;
	logic [MAX_NODES-1:0] row_rd;
	logic [MAX_NODES-1:0] row_a_q;
	logic [MAX_NODES-1:0] row_b_q;
	logic                 adding_q;
	logic [3:0]           grp_s1 [NGRP];
	logic [3:0]           grp_d  [NGRP];
	logic [LIM_W-1:0]     common_s2;
	logic [LIM_W-1:0]     common_d;
	logic                 commit_q;
	logic [TCHG_W-1:0]    tchg_q;
	logic [EDGE_W-1:0]    edge_count_q;
	logic [TRI_W-1:0]     tri_count_q;

	// output register
	logic                 accepted_q;
	logic                 status_q;
	logic [EDGE_W-1:0]    edge_total_q;
	logic [TRI_W-1:0]     tri_total_q;
	logic [TCHG_W-1:0]    tchg_out_q;

	// memory port
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [MAX_NODES-1:0] ram_wdata;
	logic                 ram_re;
	logic [IDX_W-1:0]     ram_raddr;

	// pair check against the effective node count
	logic [CMP_W-1:0] limit;
	logic [CMP_W-1:0] a_ext;
	logic [CMP_W-1:0] b_ext;
	logic             bad;

	// evaluation
	logic signed [TD_W-1:0]    dtri;
	logic signed [COEF_W:0]    ec_ext;
	logic signed [COEF_W:0]    edge_term;
	logic signed [PROD_W-1:0]  prod;
	logic signed [RATIO_W-1:0] ratio;
	logic signed [RATIO_W-1:0] draw_ext;
	logic                      commit;
	logic [NGRP*8-1:0]         and_pad;

	always_comb begin
		if (CMP_W'(node_count_q) > CMP_W'(MAX_NODES)) begin
			limit = CMP_W'(MAX_NODES);
		end else begin
			limit = CMP_W'(node_count_q);
		end
		a_ext = CMP_W'(node_a);
		b_ext = CMP_W'(node_b);
		bad   = (node_a == node_b) || (a_ext >= limit) || (b_ext >= limit);
	end

	assign stat_o.bad_pair = bad;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			ecoef_q      <= '0;
			tcoef_q      <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_NODE_COUNT: node_count_q <= cfg_data[NCOUNT_W-1:0];
				CFG_EDGE_COEF:  ecoef_q      <= cfg_data;
				CFG_TRI_COEF:   tcoef_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// adjacency memory; rows never written read as zero
	assign ram_re    = (cmd_i.take && !bad) || cmd_i.rd_b;
	assign ram_raddr = cmd_i.take ? IDX_W'(node_a) : b_idx_q;
	assign ram_we    = (cmd_i.wr_a || cmd_i.wr_b) && commit_q;
	assign ram_waddr = cmd_i.wr_a ? a_idx_q : b_idx_q;
	assign ram_wdata = cmd_i.wr_a ? (row_a_q ^ (ROW_ONE << b_idx_q))
	                              : (row_b_q ^ (ROW_ONE << a_idx_q));
	assign row_rd    = rvalid_q ? rd_data : '0;

	getmh_ram #(
		.WIDTH (MAX_NODES),
		.DEPTH (MAX_NODES)
	) u_adj (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (ram_re) begin
				rvalid_q <= valid_q[ram_raddr];
			end
		end
	end

	// per-byte popcount of the common neighbours
	assign and_pad = (NGRP*8)'(row_a_q & row_rd);

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = popcount8(and_pad[g*8 +: 8]);
		end
	end

	always_comb begin
		common_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			common_d = common_d + LIM_W'(grp_s1[g]);
		end
	end

	// log ratio: signed change times weights, exact
	always_comb begin
		dtri      = adding_q ? $signed({1'b0, common_s2}) : -$signed({1'b0, common_s2});
		ec_ext    = (COEF_W+1)'(ecoef_q);
		edge_term = adding_q ? ec_ext : -ec_ext;
		prod      = dtri * tcoef_q;
		ratio     = RATIO_W'(prod) + RATIO_W'(edge_term);
		draw_ext  = RATIO_W'(draw_q);
		commit    = (action_q == ACT_FORCE) || !ratio[RATIO_W-1] || (draw_ext < ratio);
	end

	// item payload and row staging
	always_ff @(posedge clk) begin
		if (cmd_i.take) begin
			action_q <= action;
			a_idx_q  <= IDX_W'(node_a);
			b_idx_q  <= IDX_W'(node_b);
			draw_q   <= log_uniform;
			bad_q    <= bad;
		end
		if (cmd_i.rd_b) begin
			row_a_q <= row_rd;
		end
		if (cmd_i.lat_b) begin
			row_b_q  <= row_rd;
			adding_q <= !row_a_q[b_idx_q];
			for (int g = 0; g < NGRP; g++) begin
				grp_s1[g] <= grp_d[g];
			end
		end
		if (cmd_i.sum) begin
			common_s2 <= common_d;
		end
	end

	// decision and running counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			commit_q     <= 1'b0;
			tchg_q       <= '0;
			edge_count_q <= '0;
			tri_count_q  <= '0;
		end else if (cmd_i.take) begin
			commit_q <= 1'b0;
			tchg_q   <= '0;
		end else if (cmd_i.eval) begin
			commit_q <= commit;
			tchg_q   <= TCHG_W'(dtri);
			if (commit) begin
				edge_count_q <= adding_q ? (edge_count_q + EDGE_W'(1))
				                         : (edge_count_q - EDGE_W'(1));
				tri_count_q  <= tri_count_q + TRI_W'(dtri);
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			accepted_q   <= commit_q;
			status_q     <= bad_q ? STAT_BAD_PAIR : STAT_OK;
			edge_total_q <= edge_count_q;
			tri_total_q  <= tri_count_q;
			tchg_out_q   <= tchg_q;
		end
	end

	assign accepted        = accepted_q;
	assign status          = status_q;
	assign edge_total      = edge_total_q;
	assign triangle_total  = tri_total_q;
	assign triangle_change = tchg_out_q;

	a_write_needs_commit: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (commit_q && !bad_q))
		else $error("adjacency written without a committed toggle");

	a_force_commits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_i.eval && action_q == ACT_FORCE) |-> commit)
		else $error("forced toggle not committed");

	a_counts_only_on_eval: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd_i.eval) |-> ($stable(edge_count_q) && $stable(tri_count_q)))
		else $error("counts changed outside evaluation");

endmodule

/* sv/graph_edge_toggle_mh_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_edge_toggle_mh_step
// Edge-toggle Metropolis-Hastings step over an undirected graph held as a
// symmetric adjacency bit matrix, with running edge and triangle counts.
// ----------------------------------------------------------------------------
// A valid dyad steps through S_RDB, S_POP, S_SUM, S_EVAL, S_WRA, S_WRB and
// S_DONE until its result sits in the output register, and the next input
// beat is taken the cycle after; a bad pair goes straight to S_DONE. The
// single adjacency memory sets the order: rows a and b are read one after
// the other, the common-neighbour popcount and ratio evaluation follow, and
// both rows are written back one per cycle if the toggle commits. A result
// waits in the output register while the next beat is accepted; only a second
// result blocks on a stalled output. Per-row valid bits clear the matrix
// at reset: no clearing pass, and items are taken straight out of reset.
module graph_edge_toggle_mh_step import getmh_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     action,
	input  logic [NODE_W-1:0]        node_a,
	input  logic [NODE_W-1:0]        node_b,
	input  logic signed [COEF_W-1:0] log_uniform,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     accepted,
	output logic                     status,
	output logic [EDGE_W-1:0]        edge_total,
	output logic [TRI_W-1:0]         triangle_total,
	output logic signed [TCHG_W-1:0] triangle_change
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	getmh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat_i    (stat),
		.cmd_o     (cmd)
	);

	getmh_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.action          (action),
		.node_a          (node_a),
		.node_b          (node_b),
		.log_uniform     (log_uniform),
		.cmd_i           (cmd),
		.stat_o          (stat),
		.accepted        (accepted),
		.status          (status),
		.edge_total      (edge_total),
		.triangle_total  (triangle_total),
		.triangle_change (triangle_change)
	);

endmodule
